// ===== src/min_tracking_stack_macros.svh =====
// Assertion helpers for the minimum tracking stack.
`ifndef MIN_TRACKING_STACK_MACROS_SVH
`define MIN_TRACKING_STACK_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define MTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define MTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mts_pkg.sv =====
`default_nettype none

package mts_pkg;

    localparam int STACK_DEPTH_DEF = 1024;
    localparam int DATA_W          = 32;
    localparam int COUNT_W         = 11;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TOP,
        S_TOP_SCAN,
        S_SCAN,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH,
        OP_FULL,
        OP_UNDER,
        OP_POP
    } t_op;

    // controller to datapath
    typedef struct packed {
        t_op  op;
        logic take_top;
        logic scan_start;
        logic scan_step;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic sp_one;
        logic top_is_min;
        logic scan_last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== src/mts_ctrl.sv =====
`default_nettype none

module mts_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_action,
    input  wire mts_pkg::t_stat i_stat,
    output logic               o_in_stall,
    output mts_pkg::t_cmd      o_cmd
);

    mts_pkg::t_state r_state;
    mts_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_cmd            = '{op: mts_pkg::OP_NONE, default: 1'b0};
        o_in_stall       = 1'b1;
        unique case (r_state)
            mts_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_action == mts_pkg::ACT_POP) begin
                        if (i_stat.empty) begin
                            o_cmd.op = mts_pkg::OP_UNDER;
                            n_state  = mts_pkg::S_DONE;
                        end else begin
                            o_cmd.op = mts_pkg::OP_POP;
                            if (i_stat.sp_one) begin
                                n_state = mts_pkg::S_DONE;
                            end else if (i_stat.top_is_min) begin
                                n_state = mts_pkg::S_TOP_SCAN;
                            end else begin
                                n_state = mts_pkg::S_TOP;
                            end
                        end
                    end else begin
                        o_cmd.op = i_stat.full ? mts_pkg::OP_FULL : mts_pkg::OP_PUSH;
                        n_state  = mts_pkg::S_DONE;
                    end
                end
            end
            mts_pkg::S_TOP: begin
                o_cmd.take_top = 1'b1;
                n_state        = mts_pkg::S_DONE;
            end
            mts_pkg::S_TOP_SCAN: begin
                o_cmd.take_top   = 1'b1;
                o_cmd.scan_start = 1'b1;
                n_state          = mts_pkg::S_SCAN;
            end
            mts_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = mts_pkg::S_DONE;
                end
            end
            mts_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = mts_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mts_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/mts_datapath.sv =====
`default_nettype none

module mts_datapath #(
    parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic signed [mts_pkg::DATA_W-1:0] i_value,
    input  wire mts_pkg::t_cmd                 i_cmd,
    input  wire logic                          i_out_stall,
    output mts_pkg::t_stat                     o_stat,
    output logic                               o_out_valid,
    output logic signed [mts_pkg::DATA_W-1:0]  o_top_value,
    output logic signed [mts_pkg::DATA_W-1:0]  o_min_value,
    output logic [mts_pkg::COUNT_W-1:0]        o_entry_count,
    output logic [1:0]                         o_status
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic signed [mts_pkg::DATA_W-1:0] r_mem [STACK_DEPTH];
    logic signed [mts_pkg::DATA_W-1:0] r_rd_data;

    logic [CW-1:0]                     r_sp;
    logic signed [mts_pkg::DATA_W-1:0] r_top;
    logic signed [mts_pkg::DATA_W-1:0] r_min;
    mts_pkg::t_status                  r_status;
    logic [AW-1:0]                     r_idx;
    logic                              r_out_valid;

    logic [CW-1:0]            w_sp_m1;
    logic [CW-1:0]            w_sp_m2;
    logic [AW-1:0]            w_rd_addr;
    logic [AW-1:0]            w_idx_p1;
    logic [CW+mts_pkg::COUNT_W-1:0] w_sp_ext;

    assign w_sp_m1  = r_sp - CW'(1);
    assign w_sp_m2  = r_sp - CW'(2);
    assign w_idx_p1 = r_idx + AW'(1);
    assign w_sp_ext = {{mts_pkg::COUNT_W{1'b0}}, r_sp};

    // read the new top on a pop, then sweep up from the bottom during a rescan
    always_comb begin
        priority if (i_cmd.op == mts_pkg::OP_POP) begin
            w_rd_addr = w_sp_m2[AW-1:0];
        end else if (i_cmd.scan_start) begin
            w_rd_addr = '0;
        end else begin
            w_rd_addr = w_idx_p1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == mts_pkg::OP_PUSH) begin
            r_mem[r_sp[AW-1:0]] <= i_value;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp     <= '0;
            r_top    <= '0;
            r_min    <= '0;
            r_status <= mts_pkg::ST_OK;
        end else begin
            unique case (i_cmd.op)
                mts_pkg::OP_PUSH: begin
                    r_sp     <= r_sp + CW'(1);
                    r_top    <= i_value;
                    r_status <= mts_pkg::ST_OK;
                    if ((r_sp == '0) || (i_value < r_min)) begin
                        r_min <= i_value;
                    end
                end
                mts_pkg::OP_FULL: begin
                    r_status <= mts_pkg::ST_FULL;
                end
                mts_pkg::OP_UNDER: begin
                    r_status <= mts_pkg::ST_EMPTY;
                end
                mts_pkg::OP_POP: begin
                    r_sp     <= w_sp_m1;
                    r_status <= mts_pkg::ST_OK;
                    if (r_sp == CW'(1)) begin
                        r_top <= '0;
                        r_min <= '0;
                    end
                end
                default: begin
                    if (i_cmd.take_top) begin
                        r_top <= r_rd_data;
                    end
                    if (i_cmd.scan_start) begin
                        r_min <= r_rd_data;
                    end else if (i_cmd.scan_step && (r_rd_data < r_min)) begin
                        r_min <= r_rd_data;
                    end
                end
            endcase
        end
    end

    // r_idx names the entry whose data sits in r_rd_data during the sweep
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_idx <= '0;
        end else if (i_cmd.scan_step) begin
            r_idx <= w_idx_p1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_top_value   <= r_top;
            o_min_value   <= r_min;
            o_entry_count <= w_sp_ext[mts_pkg::COUNT_W-1:0];
            o_status      <= r_status;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_stat.empty      = (r_sp == '0);
    assign o_stat.full       = (r_sp == CW'(STACK_DEPTH));
    assign o_stat.sp_one     = (r_sp == CW'(1));
    assign o_stat.top_is_min = (r_top == r_min);
    assign o_stat.scan_last  = (r_idx == w_sp_m1[AW-1:0]);
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

endmodule

`default_nettype wire

// ===== src/min_tracking_stack.sv =====
// Minimum tracking stack: a LIFO of signed 32-bit entries that reports its minimum.
// Input channel (i_in_valid / o_in_stall): one beat carries i_action (push = 0,
// pop = 1) and i_value. Output channel (o_out_valid / i_out_stall): one beat per
// input beat with the top entry, the minimum, the entry count and a status code
// (ok, push dropped because full, pop on empty ignored). Empty stack reads 0/0.
// Path from input beat to the output register, with the output free:
//   push, dropped push, ignored pop, pop that empties the stack: DONE
//   pop whose removed entry was not the minimum: TOP (one memory read), DONE
//   pop that removed the minimum: TOP_SCAN, SCAN, DONE, since the single
//   read port of the entry memory sweeps every remaining entry once.
// One beat is handled at a time: o_in_stall is high from acceptance until its
// result is loaded into the output register, so the next beat may be taken
// while that result still waits on a stalled receiver. A stalled receiver
// holds the output register and, once the next result is ready, the block.
// Reset (synchronous, active low) empties the stack, clears the minimum and
// drops any pending output beat; the entry memory needs no clearing.
`default_nettype none

`include "min_tracking_stack_macros.svh"

module min_tracking_stack #(
    parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_action,
    input  wire logic signed [mts_pkg::DATA_W-1:0] i_value,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic signed [mts_pkg::DATA_W-1:0]      o_top_value,
    output logic signed [mts_pkg::DATA_W-1:0]      o_min_value,
    output logic [mts_pkg::COUNT_W-1:0]            o_entry_count,
    output logic [1:0]                             o_status
);

    mts_pkg::t_cmd  w_cmd;
    mts_pkg::t_stat w_stat;

    // sequencer: decodes the beat, runs the rescan, hands off the result
    mts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    // entry memory, pointer, top and minimum registers, output register
    mts_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value       (i_value),
        .i_cmd         (w_cmd),
        .i_out_stall   (i_out_stall),
        .o_stat        (w_stat),
        .o_out_valid   (o_out_valid),
        .o_top_value   (o_top_value),
        .o_min_value   (o_min_value),
        .o_entry_count (o_entry_count),
        .o_status      (o_status)
    );

    // a taken beat keeps the input side stalled until its result is out
    `MTS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input taken while a beat was in flight")

    // an ignored pop only happens on an empty stack, which reads as zero
    `MTS_ASSERT_IMPL(a_empty_pop_zero, i_clk, i_rst_n, o_out_valid && (o_status == mts_pkg::ST_EMPTY), (o_entry_count == '0) && (o_top_value == '0) && (o_min_value == '0), "ignored pop with non-empty result")

    // the minimum can never exceed the top entry it covers
    `MTS_ASSERT_IMPL(a_min_le_top, i_clk, i_rst_n, o_out_valid && (o_entry_count != '0), o_min_value <= o_top_value, "minimum above top entry")

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = mts_pkg::STACK_DEPTH_DEF;
    // Watchdog bound on the run; a correct run stays well below it.
    localparam int CYCLE_LIMIT = 2_000_000;
    // Long enough to fill the output register and the stage behind it several times over.
    localparam int LONG_HOLD   = 400;
    // Entries in the deep stack, bottom minimum included, before the deep rescan.
    localparam int DEEP_FILL   = 120;
    localparam int RAND_PHASE  = 72;

    // One push or pop waiting to be offered to the block.
    typedef struct {
        logic                              action;
        logic signed [mts_pkg::DATA_W-1:0] value;
    } t_stack_op;

    // What the block must report after one beat.
    typedef struct packed {
        logic signed [mts_pkg::DATA_W-1:0] top_value;
        logic signed [mts_pkg::DATA_W-1:0] min_value;
        logic [mts_pkg::COUNT_W-1:0]       entry_count;
        mts_pkg::t_status                  status;
    } t_stack_result;

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_in_valid  = 1'b0;
    logic                              i_action    = mts_pkg::ACT_PUSH;
    logic signed [mts_pkg::DATA_W-1:0] i_value     = '0;
    logic                              i_out_stall = 1'b0;
    logic                              o_in_stall;
    logic                              o_out_valid;
    logic signed [mts_pkg::DATA_W-1:0] o_top_value;
    logic signed [mts_pkg::DATA_W-1:0] o_min_value;
    logic [mts_pkg::COUNT_W-1:0]       o_entry_count;
    logic [1:0]                        o_status;

    min_tracking_stack #(
        .STACK_DEPTH(DEPTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_top_value  (o_top_value),
        .o_min_value  (o_min_value),
        .o_entry_count(o_entry_count),
        .o_status     (o_status)
    );

    always #10 i_clk = ~i_clk;

    // Beats still to be offered, filled by the stimulus process just after a rising edge.
    t_stack_op     pending_q[$];
    // Results owed by the block, oldest first.
    t_stack_result owed_results_q[$];

    // Idling percentages for the current phase.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // Long receiver hold-off: the stimulus raises a request, the counter serves it.
    int unsigned hold_reqs   = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left   = 0;

    // Bookkeeping.
    bit in_taken;
    int items_queued  = 0;
    int beats_taken   = 0;
    int results_seen  = 0;
    int fail_count    = 0;
    int gen_depth     = 0;
    int cycle_count   = 0;
    int dropped_full  = 0;
    int ignored_empty = 0;
    int min_rescans   = 0;

    // Shadow copy of the stack, kept in step with accepted beats.
    logic signed [mts_pkg::DATA_W-1:0] shadow_mem [DEPTH];
    int                                shadow_sp  = 0;
    logic signed [mts_pkg::DATA_W-1:0] shadow_min = '0;

    // Apply one beat to the shadow stack and work out what the block must report.
    function automatic t_stack_result apply_stack_op(
        input logic act,
        input logic signed [mts_pkg::DATA_W-1:0] val);
        t_stack_result res;
        int            k;
        res.status = mts_pkg::ST_OK;
        if (act == mts_pkg::ACT_PUSH) begin
            if (shadow_sp >= DEPTH) begin
                // full: drop the push, leave everything as it was
                res.status = mts_pkg::ST_FULL;
                dropped_full++;
            end else begin
                if (shadow_sp == 0 || val < shadow_min) shadow_min = val;
                shadow_mem[shadow_sp] = val;
                shadow_sp++;
            end
        end else begin
            if (shadow_sp == 0) begin
                res.status = mts_pkg::ST_EMPTY;
                ignored_empty++;
            end else begin
                shadow_sp--;
                if (shadow_sp == 0) begin
                    shadow_min = '0;
                end else if (shadow_mem[shadow_sp] == shadow_min) begin
                    // removed a copy of the minimum: sweep what is left
                    min_rescans++;
                    shadow_min = shadow_mem[0];
                    for (k = 1; k < shadow_sp; k++)
                        if (shadow_mem[k] < shadow_min) shadow_min = shadow_mem[k];
                end
            end
        end
        res.top_value   = (shadow_sp > 0) ? shadow_mem[shadow_sp - 1] : '0;
        res.min_value   = (shadow_sp > 0) ? shadow_min : '0;
        res.entry_count = mts_pkg::COUNT_W'(shadow_sp);
        return res;
    endfunction

    // Queue a beat and track the depth it leaves, so the generator can steer the walk.
    task automatic queue_op(input logic act, input logic signed [mts_pkg::DATA_W-1:0] val);
        t_stack_op op;
        op.action = act;
        op.value  = val;
        pending_q.push_back(op);
        items_queued++;
        if (act == mts_pkg::ACT_PUSH) begin
            if (gen_depth < DEPTH) gen_depth++;
        end else if (gen_depth > 0) begin
            gen_depth--;
        end
    endtask

    // Mix extremes, a narrow band that gives plenty of equal values, and full-range noise.
    function automatic logic signed [mts_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return -32'sd1;
            3:       return 32'sd0;
            4, 5, 6: return int'($urandom_range(16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    // Random walk over the stack depth: lean towards pushes when shallow, pops when deep.
    task automatic queue_random(input int count);
        int k;
        int push_pct;
        for (k = 0; k < count; k++) begin
            push_pct = (gen_depth == 0) ? 85 : (gen_depth > 48) ? 30 : 55;
            if ($urandom_range(99) < push_pct) queue_op(mts_pkg::ACT_PUSH, pick_value());
            else                               queue_op(mts_pkg::ACT_POP, $urandom);
        end
    endtask

    // Hold until every queued beat is in and every result is out; resume after a rising edge.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (beats_taken != items_queued || owed_results_q.size() != 0);
        @(posedge i_clk);
    endtask

    // Driver: advance to the next beat only once the current one is taken.
    always @(negedge i_clk) begin : drive_in
        t_stack_op op;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                op = pending_q.pop_front();
                i_in_valid <= 1'b1;
                i_action   <= op.action;
                i_value    <= op.value;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random, or solidly while a long hold-off runs.
    always @(negedge i_clk) begin
        i_out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end

    // Count down a requested hold-off in cycles.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_reqs) begin
            hold_left   <= LONG_HOLD;
            hold_served <= hold_served + 1;
        end
    end

    // Monitor: predict on every input beat, check every output beat against the oldest owed.
    always @(posedge i_clk) begin : watch
        t_stack_result owed;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                in_taken = 1'b1;
                beats_taken++;
                owed_results_q.push_back(apply_stack_op(i_action, i_value));
            end
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (owed_results_q.size() == 0) begin
                    $error("result beat arrived with nothing owed");
                    fail_count++;
                end else begin
                    owed = owed_results_q.pop_front();
                    if (o_top_value !== owed.top_value) begin
                        $error("top_value: expected %0d, actual %0d",
                               owed.top_value, o_top_value);
                        fail_count++;
                    end
                    if (o_min_value !== owed.min_value) begin
                        $error("min_value: expected %0d, actual %0d",
                               owed.min_value, o_min_value);
                        fail_count++;
                    end
                    if (o_entry_count !== owed.entry_count) begin
                        $error("entry_count: expected %0d, actual %0d",
                               owed.entry_count, o_entry_count);
                        fail_count++;
                    end
                    if (o_status !== owed.status) begin
                        $error("status: expected %0d, actual %0d", owed.status, o_status);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        int k;
        int phase;
        int unsigned send_tab [4] = '{0, 78, 0, 36};
        int unsigned recv_tab [4] = '{0, 0, 78, 36};

        // Hold reset, then release it on a falling edge.
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-stack pop, extremes, equal copies of the minimum,
        // a pop that removes the minimum and one that empties the stack.
        queue_op(mts_pkg::ACT_POP,  32'sd0);
        queue_op(mts_pkg::ACT_PUSH, 32'sh7FFF_FFFF);
        queue_op(mts_pkg::ACT_PUSH, 32'sh8000_0000);
        queue_op(mts_pkg::ACT_PUSH, 32'sd5);
        queue_op(mts_pkg::ACT_PUSH, 32'sh8000_0000);
        queue_op(mts_pkg::ACT_POP,  32'sd0);          // one copy of the minimum goes, the other stays
        queue_op(mts_pkg::ACT_POP,  32'sd0);
        queue_op(mts_pkg::ACT_POP,  32'sd0);          // last copy of the minimum goes: rescan
        queue_op(mts_pkg::ACT_POP,  32'sd0);          // empties the stack: minimum back to 0
        queue_op(mts_pkg::ACT_POP,  32'shDEAD_BEEF);  // pop on empty, value ignored
        queue_op(mts_pkg::ACT_PUSH, -32'sd1);
        queue_op(mts_pkg::ACT_PUSH, 32'sd0);
        queue_op(mts_pkg::ACT_PUSH, 32'sd1);
        queue_op(mts_pkg::ACT_PUSH, -32'sd5);
        queue_op(mts_pkg::ACT_PUSH, 32'sd3);
        for (k = 0; k < 5; k++) queue_op(mts_pkg::ACT_POP, $urandom);
        wait_drained();

        // Build a deep stack with the minimum at the bottom, so plain pops stay cheap.
        send_idle_pct  = 36;
        recv_stall_pct = 36;
        queue_op(mts_pkg::ACT_PUSH, -32'sd2147483647);
        for (k = 1; k < DEEP_FILL; k++)
            queue_op(mts_pkg::ACT_PUSH, ($urandom | 32'h0000_0001));
        // A new minimum on top, then remove it: rescan over the whole stack.
        queue_op(mts_pkg::ACT_PUSH, 32'sh8000_0000);
        queue_op(mts_pkg::ACT_POP,  $urandom);
        for (k = 0; k < DEEP_FILL; k++) queue_op(mts_pkg::ACT_POP, $urandom);
        wait_drained();

        // Random walk under each idling pattern.
        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct  = send_tab[phase];
            recv_stall_pct = recv_tab[phase];
            queue_random(RAND_PHASE);
            if (phase == 0) begin
                // Sender flat out while the receiver holds off: fill the block up.
                @(negedge i_clk);
                hold_reqs++;
            end
            wait_drained();
        end

        // Let anything stray surface before closing.
        repeat (DEPTH + 8) @(posedge i_clk);
        if (owed_results_q.size() != 0) begin
            $error("%0d results never arrived", owed_results_q.size());
            fail_count++;
        end

        $display("Run covered %0d beats in and %0d results out over %0d cycles.",
                 beats_taken, results_seen, cycle_count);
        $display("Full pushes dropped %0d, empty pops ignored %0d, minimum rescans %0d.",
                 dropped_full, ignored_empty, min_rescans);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
